/* rtl/nrmc_pkg.sv */
package nrmc_pkg;

    typedef logic [7:0] char_t;

    localparam char_t CH_START = 8'h24;
    localparam char_t CH_END   = 8'h2A;
    localparam char_t CH_SEP   = 8'h2C;
    localparam char_t CH_A     = 8'h41;

    localparam int unsigned FLD_STATUS  = 2;
    localparam int unsigned FLD_LAT     = 3;
    localparam int unsigned FLD_LAT_DIR = 4;
    localparam int unsigned FLD_LON     = 5;
    localparam int unsigned FLD_LON_DIR = 6;

    localparam int unsigned LEN_W    = 4;
    localparam int unsigned RES_BITS = 169;
    localparam int unsigned RES_W    = 176;

    // first member sits in the top bits, so the list runs from the last field down
    typedef struct packed {
        logic [RES_W-RES_BITS-1:0] pad;
        char_t                     lon_hemisphere;
        logic [LEN_W-1:0]          lon_length;
        char_t                     lon_text_tail;
        logic [63:0]               lon_text_head;
        char_t                     lat_hemisphere;
        logic [LEN_W-1:0]          lat_length;
        char_t                     lat_text_tail;
        logic [63:0]               lat_text_head;
        logic                      fix_valid;
    } result_t;

endpackage

/* rtl/nrmc_in_reg.sv */
module nrmc_in_reg
    import nrmc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  char_t s_tdata,
    output logic  in_valid,
    output char_t in_byte,
    input  logic  in_take
);

    logic  valid_reg, valid_next;
    char_t byte_reg, byte_next;

    assign s_tready = !valid_reg || in_take;

    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            if (s_tvalid) begin
                byte_next = s_tdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

/* rtl/nrmc_core.sv */
module nrmc_core
    import nrmc_pkg::*;
#(
    parameter int unsigned FIELD_CHARS = 9,
    parameter int unsigned FIELD_SLOTS = 12
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  char_t   in_byte,
    output logic    in_take,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_result
);

    localparam int unsigned CW     = $clog2(FIELD_CHARS + 1);
    localparam int unsigned FW     = $clog2(FIELD_SLOTS);
    localparam int unsigned HEAD_N = (FIELD_CHARS < 8) ? FIELD_CHARS : 8;
    localparam bit          HAS_TAIL = (FIELD_CHARS > 8);
    localparam int unsigned TAIL_IX  = HAS_TAIL ? 8 : 0;
    localparam logic [FW-1:0] FIELD_LAST = FW'(FIELD_SLOTS - 1);

    logic          cap_reg, cap_next;
    logic [FW-1:0] field_reg, field_next;
    char_t         stat_char_reg, stat_char_next;
    logic [1:0]    stat_len_reg, stat_len_next;
    char_t         wlat_reg [FIELD_CHARS];
    char_t         wlat_next [FIELD_CHARS];
    char_t         wlon_reg [FIELD_CHARS];
    char_t         wlon_next [FIELD_CHARS];
    logic [CW-1:0] wlat_cnt_reg, wlat_cnt_next;
    logic [CW-1:0] wlon_cnt_reg, wlon_cnt_next;
    char_t         wlat_dir_reg, wlat_dir_next;
    char_t         wlon_dir_reg, wlon_dir_next;
    char_t         hlat_reg [FIELD_CHARS];
    char_t         hlat_next [FIELD_CHARS];
    char_t         hlon_reg [FIELD_CHARS];
    char_t         hlon_next [FIELD_CHARS];
    logic [CW-1:0] hlat_cnt_reg, hlat_cnt_next;
    logic [CW-1:0] hlon_cnt_reg, hlon_cnt_next;
    char_t         hlat_dir_reg, hlat_dir_next;
    char_t         hlon_dir_reg, hlon_dir_next;
    logic          mval_reg, mval_next;
    result_t       mres_reg, mres_next;

    logic is_end, emit, fix_ok;

    function automatic logic [63:0] pack_head(input char_t chars [FIELD_CHARS]);
        logic [63:0] head;
        head = '0;
        for (int i = 0; i < HEAD_N; i++) begin
            head[63-8*i -: 8] = chars[i];
        end
        return head;
    endfunction

    // a beat that ends a sentence waits for room at the output, others pass
    assign is_end  = cap_reg && (in_byte == CH_END);
    assign in_take = in_valid && (!is_end || !mval_reg || m_tready);
    assign emit    = in_take && is_end;
    assign fix_ok  = (stat_len_reg == 2'd1) && (stat_char_reg == CH_A);

    always_comb begin
        cap_next       = cap_reg;
        field_next     = field_reg;
        stat_char_next = stat_char_reg;
        stat_len_next  = stat_len_reg;
        wlat_next      = wlat_reg;
        wlon_next      = wlon_reg;
        wlat_cnt_next  = wlat_cnt_reg;
        wlon_cnt_next  = wlon_cnt_reg;
        wlat_dir_next  = wlat_dir_reg;
        wlon_dir_next  = wlon_dir_reg;
        hlat_next      = hlat_reg;
        hlon_next      = hlon_reg;
        hlat_cnt_next  = hlat_cnt_reg;
        hlon_cnt_next  = hlon_cnt_reg;
        hlat_dir_next  = hlat_dir_reg;
        hlon_dir_next  = hlon_dir_reg;

        if (in_take) begin
            if (in_byte == CH_START) begin
                cap_next       = 1'b1;
                field_next     = '0;
                stat_char_next = '0;
                stat_len_next  = '0;
                wlat_cnt_next  = '0;
                wlon_cnt_next  = '0;
                wlat_dir_next  = '0;
                wlon_dir_next  = '0;
                for (int i = 0; i < FIELD_CHARS; i++) begin
                    wlat_next[i] = '0;
                    wlon_next[i] = '0;
                end
            end else if (cap_reg) begin
                if (in_byte == CH_END) begin
                    cap_next = 1'b0;
                    if (fix_ok) begin
                        hlat_next     = wlat_reg;
                        hlon_next     = wlon_reg;
                        hlat_cnt_next = wlat_cnt_reg;
                        hlon_cnt_next = wlon_cnt_reg;
                        hlat_dir_next = wlat_dir_reg;
                        hlon_dir_next = wlon_dir_reg;
                    end
                end else if ((in_byte == CH_SEP) && (field_reg < FIELD_LAST)) begin
                    field_next = field_reg + 1'b1;
                end else if (field_reg == FW'(FLD_STATUS)) begin
                    if (stat_len_reg == 2'd0) begin
                        stat_char_next = in_byte;
                    end
                    if (stat_len_reg < 2'd2) begin
                        stat_len_next = stat_len_reg + 2'd1;
                    end
                end else if (field_reg == FW'(FLD_LAT)) begin
                    if (wlat_cnt_reg < CW'(FIELD_CHARS)) begin
                        for (int i = 0; i < FIELD_CHARS; i++) begin
                            if (wlat_cnt_reg == CW'(i)) begin
                                wlat_next[i] = in_byte;
                            end
                        end
                        wlat_cnt_next = wlat_cnt_reg + 1'b1;
                    end
                end else if (field_reg == FW'(FLD_LAT_DIR)) begin
                    if (wlat_dir_reg == '0) begin
                        wlat_dir_next = in_byte;
                    end
                end else if (field_reg == FW'(FLD_LON)) begin
                    if (wlon_cnt_reg < CW'(FIELD_CHARS)) begin
                        for (int i = 0; i < FIELD_CHARS; i++) begin
                            if (wlon_cnt_reg == CW'(i)) begin
                                wlon_next[i] = in_byte;
                            end
                        end
                        wlon_cnt_next = wlon_cnt_reg + 1'b1;
                    end
                end else if (field_reg == FW'(FLD_LON_DIR)) begin
                    if (wlon_dir_reg == '0) begin
                        wlon_dir_next = in_byte;
                    end
                end
            end
        end
    end

    // result beat is built from the held position after this sentence's update
    always_comb begin
        mval_next = mval_reg && !m_tready;
        mres_next = mres_reg;
        if (emit) begin
            mval_next                = 1'b1;
            mres_next.pad            = '0;
            mres_next.fix_valid      = fix_ok;
            mres_next.lat_text_head  = pack_head(hlat_next);
            mres_next.lat_text_tail  = HAS_TAIL ? hlat_next[TAIL_IX] : '0;
            mres_next.lat_length     = LEN_W'(hlat_cnt_next);
            mres_next.lat_hemisphere = hlat_dir_next;
            mres_next.lon_text_head  = pack_head(hlon_next);
            mres_next.lon_text_tail  = HAS_TAIL ? hlon_next[TAIL_IX] : '0;
            mres_next.lon_length     = LEN_W'(hlon_cnt_next);
            mres_next.lon_hemisphere = hlon_dir_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= 1'b0;
            field_reg     <= '0;
            stat_char_reg <= '0;
            stat_len_reg  <= '0;
            wlat_cnt_reg  <= '0;
            wlon_cnt_reg  <= '0;
            wlat_dir_reg  <= '0;
            wlon_dir_reg  <= '0;
            hlat_cnt_reg  <= '0;
            hlon_cnt_reg  <= '0;
            hlat_dir_reg  <= '0;
            hlon_dir_reg  <= '0;
            mval_reg      <= 1'b0;
            for (int i = 0; i < FIELD_CHARS; i++) begin
                wlat_reg[i] <= '0;
                wlon_reg[i] <= '0;
                hlat_reg[i] <= '0;
                hlon_reg[i] <= '0;
            end
        end else begin
            cap_reg       <= cap_next;
            field_reg     <= field_next;
            stat_char_reg <= stat_char_next;
            stat_len_reg  <= stat_len_next;
            wlat_reg      <= wlat_next;
            wlon_reg      <= wlon_next;
            wlat_cnt_reg  <= wlat_cnt_next;
            wlon_cnt_reg  <= wlon_cnt_next;
            wlat_dir_reg  <= wlat_dir_next;
            wlon_dir_reg  <= wlon_dir_next;
            hlat_reg      <= hlat_next;
            hlon_reg      <= hlon_next;
            hlat_cnt_reg  <= hlat_cnt_next;
            hlon_cnt_reg  <= hlon_cnt_next;
            hlat_dir_reg  <= hlat_dir_next;
            hlon_dir_reg  <= hlon_dir_next;
            mval_reg      <= mval_next;
        end
        mres_reg <= mres_next;
    end

    assign m_tvalid = mval_reg;
    assign m_result = mres_reg;

    a_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (mval_reg && !cap_reg))
        else $error("sentence end did not produce a result beat");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_take && (in_byte == CH_START)) |=>
            (cap_reg && (field_reg == '0) && (wlat_cnt_reg == '0) && (wlon_cnt_reg == '0)))
        else $error("start of sentence did not clear the working fields");

    a_no_fix_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !fix_ok) |=>
            ($stable(hlat_cnt_reg) && $stable(hlon_cnt_reg) &&
             $stable(hlat_dir_reg) && $stable(hlon_dir_reg)))
        else $error("held position changed on a sentence without a fix");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (wlat_cnt_reg <= CW'(FIELD_CHARS)) && (wlon_cnt_reg <= CW'(FIELD_CHARS)))
        else $error("text count beyond field length");

    a_idle_no_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (!mval_reg && !emit) |=> !mval_reg)
        else $error("result beat appeared without a sentence end");

endmodule

/* rtl/nmea_rmc_position_extractor_top.sv */
// channel | dir | ports                     | tdata fields, lowest bit up
// s_      | in  | s_tvalid s_tready s_tdata | rx_byte
// m_      | out | m_tvalid m_tready m_tdata | fix_valid, lat_text_head, lat_text_tail,
//         |     |                           | lat_length, lat_hemisphere, lon_text_head,
//         |     |                           | lon_text_tail, lon_length, lon_hemisphere
//
// one byte per cycle while no '*' beat waits; a beat is registered, decoded and its result
// registered, and that result register drives m_tvalid.
// aresetn (synchronous) clears the sentence state and the held position to zero.
// only a '*' beat waits on a full output register; other bytes keep flowing while a
// result beat is stalled.
module nmea_rmc_position_extractor_top
    import nrmc_pkg::*;
#(
    parameter int unsigned FIELD_CHARS = 9,
    parameter int unsigned FIELD_SLOTS = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,  // [7:0] rx_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    // [0] fix_valid, [64:1] lat_text_head, [72:65] lat_text_tail, [76:73] lat_length,
    // [84:77] lat_hemisphere, [148:85] lon_text_head, [156:149] lon_text_tail,
    // [160:157] lon_length, [168:161] lon_hemisphere, rest zero
    output logic [RES_W-1:0] m_tdata
);

    logic    in_valid;
    char_t   in_byte;
    logic    in_take;
    result_t m_result;

    nrmc_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_take  (in_take)
    );

    nrmc_core #(
        .FIELD_CHARS (FIELD_CHARS),
        .FIELD_SLOTS (FIELD_SLOTS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_take  (in_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = m_result;

endmodule
